// ===== src/tcw_pkg.sv =====
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int OP_W      = 2;
	localparam int GLYPH_W   = 8;
	localparam int ATTR_W    = 8;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CELL_W    = 11;
	localparam int CELL_DW   = GLYPH_W + ATTR_W;
	localparam int CUR_COL_W = $clog2(COLUMNS + 1);
	localparam int CUR_ROW_W = $clog2(ROWS + 1);

	localparam logic [GLYPH_W-1:0] NEWLINE_GLYPH = GLYPH_W'(10);
	localparam logic [GLYPH_W-1:0] SPACE_GLYPH   = GLYPH_W'(32);
	localparam logic [ATTR_W-1:0]  DEFAULT_ATTR_RESET = ATTR_W'(15);

	localparam logic [CELL_W-1:0] LAST_ROW_BASE = CELL_W'(CELL_COUNT - COLUMNS);
	localparam logic [CELL_W-1:0] LAST_COPY     = CELL_W'(CELL_COUNT - COLUMNS - 1);
	localparam logic [CELL_W-1:0] LAST_CELL     = CELL_W'(CELL_COUNT - 1);

	localparam int  APB_DW           = 32;
	localparam int  APB_AW           = 3;
	localparam logic REG_DEFAULT_ATTR = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_CLEAR,
		ST_COPY,
		ST_TAIL,
		ST_ZERO,
		ST_FIN
	} tcw_state_t;

	typedef struct packed {
		logic take_req;
		logic do_put;
		logic do_read;
		logic copy_step;
		logic tail;
		logic fill_step;
		logic fill_blank;
		logic load_out;
	} tcw_cmd_t;

	typedef struct packed {
		logic need_scroll;
		logic copy_last;
		logic fill_last;
		logic out_free;
	} tcw_status_t;

	function automatic logic [CELL_W-1:0] cell_index(
		input logic [CUR_ROW_W-1:0] r,
		input logic [CUR_COL_W-1:0] c
	);
		int idx;
		idx = int'(r) * COLUMNS + int'(c);
		return CELL_W'(idx);
	endfunction

endpackage

// ===== src/tcw_ctrl.sv =====
// Controller state machine that sequences requests, scrolls and screen sweeps.
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [tcw_pkg::OP_W-1:0] in_opcode,
	output logic                in_stall,
	input  tcw_pkg::tcw_status_t status,
	output tcw_pkg::tcw_cmd_t   cmd
);
	import tcw_pkg::*;

	tcw_state_t state_q;
	tcw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_req = 1'b1;
					case (op_t'(in_opcode))
						OP_PUT:   state_d = ST_PUT;
						OP_READ:  state_d = ST_READ;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_FIN;
					endcase
				end
			end
			ST_PUT: begin
				cmd.do_put = 1'b1;
				state_d = status.need_scroll ? ST_COPY : ST_FIN;
			end
			ST_READ: begin
				cmd.do_read = 1'b1;
				state_d = ST_FIN;
			end
			ST_CLEAR: begin
				cmd.fill_step  = 1'b1;
				cmd.fill_blank = 1'b1;
				if (status.fill_last) begin
					state_d = ST_FIN;
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (status.copy_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				cmd.tail = 1'b1;
				state_d = ST_ZERO;
			end
			ST_ZERO: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/tcw_datapath.sv =====
// Datapath: screen memory, cursor, sweep pointer and result register.
module tcw_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tcw_pkg::tcw_cmd_t                cmd,
	output tcw_pkg::tcw_status_t             status,
	input  logic [tcw_pkg::ATTR_W-1:0]       default_attribute,
	input  logic [tcw_pkg::OP_W-1:0]         opcode,
	input  logic [tcw_pkg::GLYPH_W-1:0]      glyph,
	input  logic [tcw_pkg::ATTR_W-1:0]       attribute,
	input  logic                             use_cursor,
	input  logic [tcw_pkg::COL_W-1:0]        col,
	input  logic [tcw_pkg::ROW_W-1:0]        row,
	input  logic [tcw_pkg::CELL_W-1:0]       read_cell,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tcw_pkg::CELL_W-1:0]       cursor_cell,
	output logic                             scrolled,
	output logic [tcw_pkg::GLYPH_W-1:0]      read_glyph,
	output logic [tcw_pkg::ATTR_W-1:0]       read_attribute
);
	import tcw_pkg::*;

	logic [CELL_DW-1:0] mem_q [CELL_COUNT];
	logic [CELL_DW-1:0] rd_data_q;

	op_t                  req_op_q;
	logic [GLYPH_W-1:0]   req_glyph_q;
	logic [ATTR_W-1:0]    req_attr_q;
	logic                 req_use_cursor_q;
	logic [COL_W-1:0]     req_col_q;
	logic [ROW_W-1:0]     req_row_q;
	logic [CELL_W-1:0]    req_rd_q;

	logic [CUR_COL_W-1:0] cur_col_q;
	logic [CUR_ROW_W-1:0] cur_row_q;
	logic                 scrolled_q;
	logic [CELL_W-1:0]    ptr_q;
	logic                 copy_wr_s1;
	logic [CELL_W-1:0]    copy_addr_s1;

	logic                 out_valid_q;
	logic [CELL_W-1:0]    cursor_cell_q;
	logic                 out_scrolled_q;
	logic [GLYPH_W-1:0]   read_glyph_q;
	logic [ATTR_W-1:0]    read_attribute_q;

	logic [CUR_COL_W-1:0] tgt_col;
	logic [CUR_ROW_W-1:0] tgt_row;
	logic [CUR_COL_W-1:0] nxt_col;
	logic [CUR_ROW_W-1:0] nxt_row;
	logic                 nxt_scroll;
	logic                 is_newline;
	logic [ATTR_W-1:0]    attr_eff;
	logic                 rd_in_range;

	logic                 wr_en;
	logic [CELL_W-1:0]    wr_addr;
	logic [CELL_DW-1:0]   wr_data;
	logic                 rd_en;
	logic [CELL_W-1:0]    rd_addr;

	assign is_newline  = (req_glyph_q == NEWLINE_GLYPH);
	assign attr_eff    = (req_attr_q == '0) ? default_attribute : req_attr_q;
	assign rd_in_range = (int'(req_rd_q) < CELL_COUNT);

	always_comb begin
		int c;
		int r;
		c = int'(req_col_q);
		r = int'(req_row_q);
		if (c >= COLUMNS) begin
			c = COLUMNS - 1;
		end
		if (r >= ROWS) begin
			r = ROWS - 1;
		end
		if (req_use_cursor_q) begin
			tgt_col = cur_col_q;
			tgt_row = cur_row_q;
		end else begin
			tgt_col = CUR_COL_W'(c);
			tgt_row = CUR_ROW_W'(r);
		end
	end

	always_comb begin
		nxt_scroll = 1'b0;
		if (is_newline || (tgt_col == CUR_COL_W'(COLUMNS - 1))) begin
			nxt_col = '0;
			if (tgt_row == CUR_ROW_W'(ROWS - 1)) begin
				nxt_row    = tgt_row;
				nxt_scroll = 1'b1;
			end else begin
				nxt_row = tgt_row + CUR_ROW_W'(1);
			end
		end else begin
			nxt_col = tgt_col + CUR_COL_W'(1);
			nxt_row = tgt_row;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '0;
		if (copy_wr_s1) begin
			wr_en   = 1'b1;
			wr_addr = copy_addr_s1;
			wr_data = rd_data_q;
		end else if (cmd.do_put && !is_newline) begin
			wr_en   = 1'b1;
			wr_addr = cell_index(tgt_row, tgt_col);
			wr_data = {attr_eff, req_glyph_q};
		end else if (cmd.fill_step) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = cmd.fill_blank ? {default_attribute, SPACE_GLYPH} : '0;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = req_rd_q;
		if (cmd.copy_step) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q + CELL_W'(COLUMNS);
		end else if (cmd.do_read && rd_in_range) begin
			rd_en   = 1'b1;
			rd_addr = req_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			req_op_q         <= op_t'(opcode);
			req_glyph_q      <= glyph;
			req_attr_q       <= attribute;
			req_use_cursor_q <= use_cursor;
			req_col_q        <= col;
			req_row_q        <= row;
			req_rd_q         <= read_cell;
		end
		copy_addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			scrolled_q <= 1'b0;
			ptr_q      <= '0;
			copy_wr_s1 <= 1'b0;
		end else begin
			copy_wr_s1 <= cmd.copy_step;
			if (cmd.take_req) begin
				ptr_q      <= '0;
				scrolled_q <= 1'b0;
				if (op_t'(opcode) == OP_CLEAR) begin
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
			end else if (cmd.tail) begin
				ptr_q <= LAST_ROW_BASE;
			end else if (cmd.copy_step || cmd.fill_step) begin
				ptr_q <= ptr_q + CELL_W'(1);
			end
			if (cmd.do_put) begin
				cur_col_q  <= nxt_col;
				cur_row_q  <= nxt_row;
				scrolled_q <= nxt_scroll;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cursor_cell_q  <= cell_index(cur_row_q, cur_col_q);
			out_scrolled_q <= scrolled_q;
			if ((req_op_q == OP_READ) && rd_in_range) begin
				read_glyph_q     <= rd_data_q[GLYPH_W-1:0];
				read_attribute_q <= rd_data_q[CELL_DW-1:GLYPH_W];
			end else begin
				read_glyph_q     <= '0;
				read_attribute_q <= '0;
			end
		end
	end

	assign status.need_scroll = nxt_scroll;
	assign status.copy_last   = (ptr_q == LAST_COPY);
	assign status.fill_last   = (ptr_q == LAST_CELL);
	assign status.out_free    = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign cursor_cell    = cursor_cell_q;
	assign scrolled       = out_scrolled_q;
	assign read_glyph     = read_glyph_q;
	assign read_attribute = read_attribute_q;

endmodule

// ===== src/text_console_writer_unit.sv =====
// Top level of the text console writer: register port, controller and datapath.
// A put or read request passes through its PUT or READ state and then FIN, where the result
// registers are loaded once the output is free; a no-op goes straight to FIN. in_stall is high
// outside IDLE, so no new request is taken until the last result is loaded. A put that scrolls
// copies each cell up one row (registered read, then write) and zeroes the last row; a clear
// writes blanks, one cell per cycle. After reset the screen memory is swept to zero with
// in_stall high; register writes are taken during that time.
module text_console_writer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tcw_pkg::OP_W-1:0]          opcode,
	input  logic [tcw_pkg::GLYPH_W-1:0]       glyph,
	input  logic [tcw_pkg::ATTR_W-1:0]        attribute,
	input  logic                              use_cursor,
	input  logic [tcw_pkg::COL_W-1:0]         col,
	input  logic [tcw_pkg::ROW_W-1:0]         row,
	input  logic [tcw_pkg::CELL_W-1:0]        read_cell,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcw_pkg::CELL_W-1:0]        cursor_cell,
	output logic                              scrolled,
	output logic [tcw_pkg::GLYPH_W-1:0]       read_glyph,
	output logic [tcw_pkg::ATTR_W-1:0]        read_attribute,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcw_pkg::APB_AW-1:0]        paddr,
	input  logic [tcw_pkg::APB_DW-1:0]        pwdata,
	output logic [tcw_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);
	import tcw_pkg::*;

	logic [ATTR_W-1:0] def_attr_q;
	logic              reg_sel;
	tcw_cmd_t          cmd;
	tcw_status_t       status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1] == REG_DEFAULT_ATTR);
	assign prdata  = reg_sel ? {{(APB_DW-ATTR_W){1'b0}}, def_attr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_attr_q <= DEFAULT_ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			def_attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (opcode),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tcw_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.default_attribute (def_attr_q),
		.opcode            (opcode),
		.glyph             (glyph),
		.attribute         (attribute),
		.use_cursor        (use_cursor),
		.col               (col),
		.row               (row),
		.read_cell         (read_cell),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.cursor_cell       (cursor_cell),
		.scrolled          (scrolled),
		.read_glyph        (read_glyph),
		.read_attribute    (read_attribute)
	);

endmodule
